// ----- src/qru_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qru_pkg: shared types and constants of the quaternion rotation unit
// Command codes, result record, Q2.30 angle constants, arctangent table.
// ----------------------------------------------------------------------------
package qru_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 20;

  typedef enum logic [2:0] {
    CMD_MUL  = 3'd0,
    CMD_INV  = 3'd1,
    CMD_NSQ  = 3'd2,
    CMD_NORM = 3'd3,
    CMD_ROT  = 3'd4,
    CMD_VROT = 3'd5
  } cmd_t;

  typedef struct packed {
    logic               fault;
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
    logic signed [31:0] w;
  } res_t;

  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] GAIN_Q30    = 36'sd652032874;

  localparam logic [29:0] ATAN_Q30 [32] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
    30'd67021688,  30'd33543516,  30'd16775851,  30'd8388437,
    30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
    30'd262144,    30'd131072,    30'd65536,     30'd32768,
    30'd16384,     30'd8192,      30'd4096,      30'd2048,
    30'd1024,      30'd512,       30'd256,       30'd128,
    30'd64,        30'd32,        30'd16,        30'd8,
    30'd4,         30'd2,         30'd1,         30'd0
  };

  // {overflow, value} clamped to the signed 32-bit range
  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    logic [32:0] r;
    if (v > 64'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -64'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/qru_delay.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qru_delay: enabled delay line
// Moves a word N stages forward whenever the pipeline advances.
// ----------------------------------------------------------------------------
module qru_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  generate
    if (N == 0) begin : g_none
      assign q = d;
    end else begin : g_pipe
      logic [W-1:0] pipe_r [N];
      always_ff @(posedge clk) begin
        if (en) begin
          pipe_r[0] <= d;
          for (int k = 1; k < N; k++) begin
            pipe_r[k] <= pipe_r[k-1];
          end
        end
      end
      assign q = pipe_r[N-1];
    end
  endgenerate

endmodule
`default_nettype wire

// ----- src/quaternion_rotation_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_rotation_unit: Q16.16 quaternion arithmetic pipeline
// Hamilton product, inverse, squared norm, norm, rotation from angle and
// vector rotation, one request per clock while the pipe is not stalled.
// ----------------------------------------------------------------------------
// Fully pipelined: a new request is taken every clock while the pipe is not
// stalled. The angle path (reduction of the half angle modulo 2*pi, one
// subtract per stage, then one CORDIC rotation per stage) sets the depth
// when it is the longest path; the divider and square root run 32 one-bit
// stages in parallel and are padded to match. All stages advance together:
// in_tready drops only while the output register holds an untaken result.
// Commands 6 and 7 return zeros with fault clear.
// ----------------------------------------------------------------------------
module quaternion_rotation_unit
  import qru_pkg::*;
#(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // command[2:0], a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, v_x, v_y, v_z
  input  logic [359:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // r_w[31:0], r_x, r_y, r_z, fault[128]
  output logic [135:0] out_tdata
);

  localparam int SH        = 30 - FRAC_BITS;
  localparam int RED_STEPS = (FRAC_BITS < 28) ? 29 - FRAC_BITS : 1;
  localparam int M_W       = 62 - FRAC_BITS;
  localparam int LAT_H     = 4;
  localparam int LAT_N     = 37;
  localparam int LAT_C     = RED_STEPS + CORDIC_STEPS + 6;
  localparam int LAT_HN    = (LAT_H > LAT_N) ? LAT_H : LAT_N;
  localparam int LAT_MAX   = (LAT_HN > LAT_C) ? LAT_HN : LAT_C;
  localparam int LAT       = LAT_MAX + 1;

  typedef logic signed [63:0] prod_t [4][4];

  typedef struct packed {
    logic [3:0][62:0] rem;
    logic [3:0][31:0] quo;
    logic [3:0]       ovf;
    logic [3:0]       neg;
    logic [30:0]      dvs;
    logic             dvs_sat;
    logic             zero;
    logic             carry;
    logic [63:0]      rad;
    logic [63:0]      root;
  } nrm_t;

  typedef struct packed {
    logic [M_W-1:0] m;
    logic           hneg;
  } red_t;

  typedef struct packed {
    logic signed [35:0] x;
    logic signed [35:0] y;
    logic signed [35:0] z;
    logic               neg;
  } cor_t;

  // ---- helpers --------------------------------------------------------------
  function automatic logic signed [63:0] fx(input logic signed [63:0] p);
    return p >>> FRAC_BITS;
  endfunction

  // Hamilton product from the 16 partial products p[i][j] = P_i * Q_j
  function automatic res_t ham(input prod_t p);
    logic signed [63:0] s0, s1, s2, s3;
    logic [32:0]        t0, t1, t2, t3;
    res_t               r;
    s0 = fx(p[0][0]) - fx(p[1][1]) - fx(p[2][2]) - fx(p[3][3]);
    s1 = fx(p[0][1]) + fx(p[1][0]) + fx(p[2][3]) - fx(p[3][2]);
    s2 = fx(p[0][2]) - fx(p[1][3]) + fx(p[2][0]) + fx(p[3][1]);
    s3 = fx(p[0][3]) + fx(p[1][2]) - fx(p[2][1]) + fx(p[3][0]);
    t0 = sat32(s0);
    t1 = sat32(s1);
    t2 = sat32(s2);
    t3 = sat32(s3);
    r.w     = t0[31:0];
    r.x     = t1[31:0];
    r.y     = t2[31:0];
    r.z     = t3[31:0];
    r.fault = t0[32] | t1[32] | t2[32] | t3[32];
    return r;
  endfunction

  // one quotient bit for each divider lane and one root bit
  function automatic nrm_t nrm_step(input nrm_t s, input int k);
    nrm_t        o;
    logic [62:0] d;
    logic [63:0] bit_v;
    logic [63:0] trial;
    o = s;
    d = 63'(s.dvs) << (31 - k);
    for (int i = 0; i < 4; i++) begin
      if (s.rem[i] >= d) begin
        o.rem[i]        = s.rem[i] - d;
        o.quo[i][31-k]  = 1'b1;
      end
    end
    bit_v = 64'd1 << (62 - 2 * k);
    trial = s.root + bit_v;
    if (s.rad >= trial) begin
      o.rad  = s.rad - trial;
      o.root = (s.root >> 1) + bit_v;
    end else begin
      o.root = s.root >> 1;
    end
    return o;
  endfunction

  function automatic cor_t cor_step(input cor_t s, input int i);
    cor_t o;
    o = s;
    if (s.z >= 0) begin
      o.x = s.x - (s.y >>> i);
      o.y = s.y + (s.x >>> i);
      o.z = s.z - $signed({6'b0, ATAN_Q30[i]});
    end else begin
      o.x = s.x + (s.y >>> i);
      o.y = s.y - (s.x >>> i);
      o.z = s.z + $signed({6'b0, ATAN_Q30[i]});
    end
    return o;
  endfunction

  // ---- input unpack, flow control ---------------------------------------------
  logic        [2:0]  in_cmd;
  logic signed [31:0] in_a [4];
  logic signed [31:0] in_b [4];
  logic signed [31:0] in_v [4];

  always_comb begin
    in_cmd  = in_tdata[2:0];
    in_v[0] = '0;
    for (int i = 0; i < 4; i++) begin
      in_a[i] = in_tdata[3 + 32*i +: 32];
      in_b[i] = in_tdata[131 + 32*i +: 32];
    end
    for (int i = 1; i < 4; i++) begin
      in_v[i] = in_tdata[259 + 32*(i-1) +: 32];
    end
  end

  logic [LAT:1] vld_r;
  logic [LAT:1] vld_nxt;
  logic [2:0]   cmd_r [1:LAT-1];
  logic         en;

  // the whole pipe moves unless the output register is full and stalled
  assign en        = !vld_r[LAT] || out_tready;
  assign in_tready = en;
  assign vld_nxt   = {vld_r[LAT-1:1], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // command of the request held in each stage
  always_ff @(posedge clk) begin
    if (en) begin
      cmd_r[1] <= in_cmd;
      for (int k = 2; k <= LAT - 1; k++) begin
        cmd_r[k] <= cmd_r[k-1];
      end
    end
  end

  // ---- Hamilton path: a*b, or a*(0,v) then *b ----------------------------------
  logic signed [31:0] qop [4];
  prod_t              h_p1_r;
  prod_t              h_p2_r;
  logic signed [31:0] h_b1_r [4];
  logic signed [31:0] h_b2_r [4];
  res_t               h_t_r;
  res_t               h_t3_r;
  res_t               h_res_r;
  res_t               h_two;
  logic signed [31:0] h_tv [4];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      qop[j] = (in_cmd == CMD_VROT) ? in_v[j] : in_b[j];
    end
    h_tv[0] = h_t_r.w;
    h_tv[1] = h_t_r.x;
    h_tv[2] = h_t_r.y;
    h_tv[3] = h_t_r.z;
    h_two   = ham(h_p2_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          h_p1_r[i][j] <= in_a[i] * qop[j];
          h_p2_r[i][j] <= h_tv[i] * h_b2_r[j];
        end
        h_b1_r[i] <= in_b[i];
        h_b2_r[i] <= h_b1_r[i];
      end
      h_t_r  <= ham(h_p1_r);
      h_t3_r <= h_t_r;
      if (cmd_r[3] == CMD_VROT) begin
        h_res_r.w     <= '0;
        h_res_r.x     <= h_two.x;
        h_res_r.y     <= h_two.y;
        h_res_r.z     <= h_two.z;
        h_res_r.fault <= h_two.fault | h_t3_r.fault;
      end else begin
        h_res_r <= h_t3_r;
      end
    end
  end

  // ---- norm path: squares, squared norm, divider lanes, square root ------------
  logic        [63:0] n_sq_r [4];
  logic signed [31:0] n_a1_r [4];
  logic signed [31:0] n_a2_r [4];
  logic signed [31:0] n_a3_r [4];
  logic        [64:0] n_sum_r;
  logic        [64:0] n_sum3_r;
  logic        [30:0] n_n2_r;
  logic               n_n2f_r;
  logic        [63:0] n_sh;
  logic               n_sat;
  nrm_t               n_init;
  nrm_t               nst_r [0:32];
  nrm_t               n_last;
  res_t               n_res_r;
  res_t               n_res_nxt;
  logic        [31:0] n_mag;
  logic        [62:0] n_dvd;
  logic        [31:0] n_val;
  logic               n_ovf;

  assign n_sh  = n_sum_r[63:0] >> FRAC_BITS;
  assign n_sat = n_sum_r[64] || (n_sh > 64'h0000_0000_7FFF_FFFF);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        n_sq_r[i] <= in_a[i] * in_a[i];
        n_a1_r[i] <= in_a[i];
        n_a2_r[i] <= n_a1_r[i];
        n_a3_r[i] <= n_a2_r[i];
      end
      n_sum_r  <= 65'(n_sq_r[0]) + 65'(n_sq_r[1]) + 65'(n_sq_r[2]) + 65'(n_sq_r[3]);
      n_sum3_r <= n_sum_r;
      n_n2_r   <= n_sat ? 31'h7FFF_FFFF : n_sh[30:0];
      n_n2f_r  <= n_sat;
    end
  end

  // divider setup: |a_i| << FRAC_BITS over the squared norm
  always_comb begin
    n_init         = '0;
    n_init.dvs     = n_n2_r;
    n_init.dvs_sat = n_n2f_r;
    n_init.zero    = (n_n2_r == '0);
    n_init.carry   = n_sum3_r[64];
    n_init.rad     = n_sum3_r[63:0];
    n_mag          = '0;
    n_dvd          = '0;
    for (int i = 0; i < 4; i++) begin
      n_mag            = n_a3_r[i][31] ? 32'd0 - n_a3_r[i] : n_a3_r[i];
      n_dvd            = 63'(n_mag) << FRAC_BITS;
      n_init.rem[i]    = n_dvd;
      n_init.ovf[i]    = n_dvd >= (63'(n_n2_r) << 32);
      n_init.neg[i]    = (i == 0) ? n_a3_r[i][31]
                                  : (!n_a3_r[i][31] && (n_a3_r[i] != '0));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nst_r[0] <= n_init;
    end
  end

  for (genvar k = 0; k < 32; k++) begin : g_nrm
    always_ff @(posedge clk) begin
      if (en) begin
        nst_r[k+1] <= nrm_step(nst_r[k], k);
      end
    end
  end

  assign n_last = nst_r[32];

  always_comb begin
    n_res_nxt = '0;
    n_val     = '0;
    n_ovf     = 1'b0;
    unique case (cmd_r[LAT_N-1])
      CMD_INV: begin
        n_res_nxt.fault = n_last.dvs_sat;
        for (int i = 0; i < 4; i++) begin
          n_ovf = n_last.ovf[i] ||
                  (n_last.neg[i] ? (n_last.quo[i] > 32'h8000_0000) : n_last.quo[i][31]);
          if (n_ovf) begin
            n_val = n_last.neg[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
          end else begin
            n_val = n_last.neg[i] ? 32'd0 - n_last.quo[i] : n_last.quo[i];
          end
          n_res_nxt.fault = n_res_nxt.fault | n_ovf;
          case (i)
            0:       n_res_nxt.w = n_val;
            1:       n_res_nxt.x = n_val;
            2:       n_res_nxt.y = n_val;
            default: n_res_nxt.z = n_val;
          endcase
        end
        if (n_last.zero) begin
          n_res_nxt       = '0;
          n_res_nxt.fault = 1'b1;
        end
      end
      CMD_NSQ: begin
        n_res_nxt.w     = {1'b0, n_last.dvs};
        n_res_nxt.fault = n_last.dvs_sat;
      end
      CMD_NORM: begin
        if (n_last.carry || (n_last.root[63:31] != '0)) begin
          n_res_nxt.w     = 32'h7FFF_FFFF;
          n_res_nxt.fault = 1'b1;
        end else begin
          n_res_nxt.w = n_last.root[31:0];
        end
      end
      default: n_res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_res_r <= n_res_nxt;
    end
  end

  // ---- angle path: half angle, reduction, fold, CORDIC, axis scaling -----------
  logic signed [63:0] c_hext;
  logic signed [63:0] c_h;
  red_t               rst_r [0:RED_STEPS];
  red_t               c_red_last;
  logic signed [35:0] c_w;
  logic signed [35:0] c_za_r;
  cor_t               c_fold;
  cor_t               cst_r [0:CORDIC_STEPS];
  logic signed [35:0] c_xs;
  logic signed [35:0] c_ys;
  logic signed [35:0] c_cs_r;
  logic signed [35:0] c_sn_r;
  logic signed [35:0] c_cs2_r;
  logic signed [67:0] c_pr_r [1:3];
  logic [95:0]        c_axis_d;
  logic signed [31:0] c_axis [1:3];
  res_t               c_res_r;
  res_t               c_res_nxt;
  logic [32:0]        c_t0;
  logic [32:0]        c_t1;
  logic [32:0]        c_t2;
  logic [32:0]        c_t3;

  assign c_hext = 64'(in_a[0]);
  assign c_h    = (c_hext <<< SH) >>> 1;

  always_ff @(posedge clk) begin
    if (en) begin
      rst_r[0].hneg <= c_h[63];
      rst_r[0].m    <= M_W'(c_h[63] ? -c_h : c_h);
    end
  end

  // magnitude modulo 2*pi, largest multiple first
  for (genvar k = 0; k < RED_STEPS; k++) begin : g_red
    localparam logic [63:0] STEP_V = 64'(TWO_PI_Q30) << (RED_STEPS - 1 - k);
    always_ff @(posedge clk) begin
      if (en) begin
        rst_r[k+1].hneg <= rst_r[k].hneg;
        if (64'(rst_r[k].m) >= STEP_V) begin
          rst_r[k+1].m <= M_W'(64'(rst_r[k].m) - STEP_V);
        end else begin
          rst_r[k+1].m <= rst_r[k].m;
        end
      end
    end
  end

  assign c_red_last = rst_r[RED_STEPS];

  // wrap into [-pi, pi] and put the sign back
  always_comb begin
    if ($signed(36'(c_red_last.m)) > PI_Q30) begin
      c_w = $signed(36'(c_red_last.m)) - TWO_PI_Q30;
    end else begin
      c_w = $signed(36'(c_red_last.m));
    end
  end

  // fold into [-pi/2, pi/2]; the sign flip is applied after the rotations
  always_comb begin
    c_fold.x   = GAIN_Q30;
    c_fold.y   = '0;
    c_fold.z   = c_za_r;
    c_fold.neg = 1'b0;
    if (c_za_r > HALF_PI_Q30) begin
      c_fold.z   = c_za_r - PI_Q30;
      c_fold.neg = 1'b1;
    end else if (c_za_r < -HALF_PI_Q30) begin
      c_fold.z   = c_za_r + PI_Q30;
      c_fold.neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_za_r   <= c_red_last.hneg ? -c_w : c_w;
      cst_r[0] <= c_fold;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cor
    always_ff @(posedge clk) begin
      if (en) begin
        cst_r[i+1] <= cor_step(cst_r[i], i);
      end
    end
  end

  assign c_xs = cst_r[CORDIC_STEPS].neg ? -cst_r[CORDIC_STEPS].x : cst_r[CORDIC_STEPS].x;
  assign c_ys = cst_r[CORDIC_STEPS].neg ? -cst_r[CORDIC_STEPS].y : cst_r[CORDIC_STEPS].y;

  qru_delay #(
    .W (96),
    .N (LAT_C - 2)
  ) u_axis_dly (
    .clk (clk),
    .en  (en),
    .d   ({in_a[3], in_a[2], in_a[1]}),
    .q   (c_axis_d)
  );

  assign c_axis[1] = c_axis_d[31:0];
  assign c_axis[2] = c_axis_d[63:32];
  assign c_axis[3] = c_axis_d[95:64];

  always_ff @(posedge clk) begin
    if (en) begin
      c_cs_r  <= c_xs >>> SH;
      c_sn_r  <= c_ys >>> SH;
      c_cs2_r <= c_cs_r;
      for (int i = 1; i < 4; i++) begin
        c_pr_r[i] <= c_axis[i] * c_sn_r;
      end
      c_res_r <= c_res_nxt;
    end
  end

  always_comb begin
    c_t0            = sat32(64'(c_cs2_r));
    c_t1            = sat32(64'(c_pr_r[1] >>> FRAC_BITS));
    c_t2            = sat32(64'(c_pr_r[2] >>> FRAC_BITS));
    c_t3            = sat32(64'(c_pr_r[3] >>> FRAC_BITS));
    c_res_nxt.w     = c_t0[31:0];
    c_res_nxt.x     = c_t1[31:0];
    c_res_nxt.y     = c_t2[31:0];
    c_res_nxt.z     = c_t3[31:0];
    c_res_nxt.fault = c_t0[32] | c_t1[32] | c_t2[32] | c_t3[32];
  end

  // ---- align the three paths and pick the result --------------------------------
  res_t h_al;
  res_t n_al;
  res_t c_al;
  res_t out_res_r;

  qru_delay #(.W ($bits(res_t)), .N (LAT - 1 - LAT_H)) u_h_dly (
    .clk (clk), .en (en), .d (h_res_r), .q (h_al)
  );

  qru_delay #(.W ($bits(res_t)), .N (LAT - 1 - LAT_N)) u_n_dly (
    .clk (clk), .en (en), .d (n_res_r), .q (n_al)
  );

  qru_delay #(.W ($bits(res_t)), .N (LAT - 1 - LAT_C)) u_c_dly (
    .clk (clk), .en (en), .d (c_res_r), .q (c_al)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      unique case (cmd_r[LAT-1])
        CMD_MUL, CMD_VROT:          out_res_r <= h_al;
        CMD_INV, CMD_NSQ, CMD_NORM: out_res_r <= n_al;
        CMD_ROT:                    out_res_r <= c_al;
        default:                    out_res_r <= '0;
      endcase
    end
  end

  assign out_tvalid = vld_r[LAT];
  assign out_tdata  = {7'b0, out_res_r};

endmodule
`default_nettype wire

// ----- tb/quaternion_rotation_unit_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_rotation_unit_chk: result checker for the quaternion unit
// Computes the expected result of every accepted request in Q16.16 fixed
// point and compares each returned result with the oldest expected one.
// ----------------------------------------------------------------------------
module quaternion_rotation_unit_chk
  import qru_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [359:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [135:0] out_tdata,
  output int           fail_count,
  output int           pending
);

  localparam int FB = 16;
  localparam int STEPS = 20;

  logic [135:0] expected_q[$];

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp32(longint v, ref bit ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint fx_mul(longint p, longint q);
    return floor_shr(p * q, FB);
  endfunction

  function automatic void ham_prod(input longint p[4], input longint q[4],
                                   output longint r[4], ref bit ovf);
    r[0] = clamp32(fx_mul(p[0], q[0]) - fx_mul(p[1], q[1]) - fx_mul(p[2], q[2])
                   - fx_mul(p[3], q[3]), ovf);
    r[1] = clamp32(fx_mul(p[0], q[1]) + fx_mul(p[1], q[0]) + fx_mul(p[2], q[3])
                   - fx_mul(p[3], q[2]), ovf);
    r[2] = clamp32(fx_mul(p[0], q[2]) - fx_mul(p[1], q[3]) + fx_mul(p[2], q[0])
                   + fx_mul(p[3], q[1]), ovf);
    r[3] = clamp32(fx_mul(p[0], q[3]) + fx_mul(p[1], q[2]) - fx_mul(p[2], q[1])
                   + fx_mul(p[3], q[0]), ovf);
  endfunction

  // exact sum of four squares; carry out of 64 bits reported separately
  function automatic logic [64:0] sum_squares(input longint p[4]);
    logic [64:0] s;
    s = '0;
    for (int i = 0; i < 4; i++) s = s + 65'(longint'(p[i] * p[i]));
    return s;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic void cordic_sincos(input longint ang, output longint sn,
                                        output longint cs);
    longint h, x, y, z, nx;
    bit flip;
    h = floor_shr(ang * (longint'(1) << (30 - FB)), 1);
    x = GAIN_Q30;
    y = 0;
    flip = 0;
    z = h % longint'(TWO_PI_Q30);
    if (z > PI_Q30) z = z - TWO_PI_Q30;
    if (z < -PI_Q30) z = z + TWO_PI_Q30;
    if (z > HALF_PI_Q30) begin
      z = z - PI_Q30;
      flip = 1;
    end else if (z < -HALF_PI_Q30) begin
      z = z + PI_Q30;
      flip = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - floor_shr(y, i);
        y = y + floor_shr(x, i);
        z = z - longint'(ATAN_Q30[i]);
      end else begin
        nx = x + floor_shr(y, i);
        y = y - floor_shr(x, i);
        z = z + longint'(ATAN_Q30[i]);
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cs = floor_shr(x, 30 - FB);
    sn = floor_shr(y, 30 - FB);
  endfunction

  function automatic logic [135:0] quat_result(logic [359:0] d);
    longint a[4], b[4], v[4], r[4], t[4], sn, cs, n2;
    logic [64:0] sq;
    logic [63:0] root;
    bit ovf;
    logic [2:0] op;
    op = d[2:0];
    ovf = 0;
    for (int i = 0; i < 4; i++) begin
      a[i] = longint'($signed(d[3 + 32*i +: 32]));
      b[i] = longint'($signed(d[131 + 32*i +: 32]));
      r[i] = 0;
    end
    v[0] = 0;
    for (int i = 1; i < 4; i++) v[i] = longint'($signed(d[259 + 32*(i-1) +: 32]));
    case (op)
      CMD_MUL: ham_prod(a, b, r, ovf);
      CMD_INV, CMD_NSQ: begin
        sq = sum_squares(a);
        if (sq[64] || (sq[63:0] >> FB) > 64'd2147483647) begin
          n2 = 2147483647;
          ovf = 1;
        end else begin
          n2 = longint'(sq[63:0] >> FB);
        end
        if (op == CMD_NSQ) r[0] = n2;
        else if (n2 == 0) ovf = 1;
        else begin
          r[0] = clamp32((a[0] * (longint'(1) << FB)) / n2, ovf);
          for (int i = 1; i < 4; i++)
            r[i] = clamp32((-a[i] * (longint'(1) << FB)) / n2, ovf);
        end
      end
      CMD_NORM: begin
        sq = sum_squares(a);
        if (sq[64]) begin
          r[0] = 2147483647;
          ovf = 1;
        end else begin
          root = int_sqrt(sq[63:0]);
          if (root > 64'd2147483647) begin
            r[0] = 2147483647;
            ovf = 1;
          end else begin
            r[0] = longint'(root);
          end
        end
      end
      CMD_ROT: begin
        cordic_sincos(a[0], sn, cs);
        r[0] = clamp32(cs, ovf);
        for (int i = 1; i < 4; i++) r[i] = clamp32(fx_mul(a[i], sn), ovf);
      end
      CMD_VROT: begin
        ham_prod(a, v, t, ovf);
        ham_prod(t, b, r, ovf);
        r[0] = 0;
      end
      default: ;
    endcase
    return {7'd0, ovf, r[3][31:0], r[2][31:0], r[1][31:0], r[0][31:0]};
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    logic [135:0] exp_r;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready) expected_q.push_back(quat_result(in_tdata));
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r[128:0] !== out_tdata[128:0]) begin
            $display("%0t: mismatch expected w=%h x=%h y=%h z=%h f=%b", $time,
                     exp_r[31:0], exp_r[63:32], exp_r[95:64], exp_r[127:96], exp_r[128]);
            $display("%0t:          actual   w=%h x=%h y=%h z=%h f=%b", $time,
                     out_tdata[31:0], out_tdata[63:32], out_tdata[95:64],
                     out_tdata[127:96], out_tdata[128]);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- tb/quaternion_rotation_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_rotation_unit_tb: stimulus and verdict for the quaternion unit
// Directed corner requests for every command, then random requests with
// random idle bursts on both channels; the checker compares all results.
// ----------------------------------------------------------------------------
module quaternion_rotation_unit_tb;
  import qru_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [359:0] in_tdata;   // command[2:0], a_w..a_z, b_w..b_z, v_x..v_z
  logic         out_tvalid;
  logic         out_tready;
  logic [135:0] out_tdata;  // r_w, r_x, r_y, r_z, fault[128]
  int           fail_count;
  int           pending;
  bit           calm;       // no idling near the end of the run

  quaternion_rotation_unit u_top (.*);

  quaternion_rotation_unit_chk u_chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Q16.16 constants
  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] PMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NMAX = 32'h8000_0000;
  localparam logic [31:0] PI   = 32'h0003_243F;

  // random 32-bit field: mostly modest magnitudes so products stay in range,
  // sometimes full-range words to hit saturation
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? PMAX : NMAX;
      2: return 32'(int'($urandom_range(0, 8)) - 4) <<< 16;
      default: return 32'($signed(20'($urandom())));
    endcase
  endfunction

  task automatic send(logic [2:0] op, logic [31:0] f[11]);
    logic [359:0] d;
    d = {3'd0, 357'd0};
    d[2:0] = op;
    for (int i = 0; i < 11; i++) d[3 + 32*i +: 32] = f[i];
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_tdata  <= d;
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_rand(logic [2:0] op);
    logic [31:0] f[11];
    for (int i = 0; i < 11; i++) f[i] = rand_word();
    send(op, f);
  endtask

  // sink stall bursts
  initial begin
    out_tready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_tready <= 0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      out_tready <= 1;
    end
  end

  initial begin
    logic [31:0] f[11];
    int wait_cnt;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    calm = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: identity, extremes, zero-norm inverse, angles, unknown codes
    for (int i = 0; i < 11; i++) f[i] = 0;
    f[0] = ONE; f[4] = ONE;
    send(CMD_MUL, f);
    for (int i = 0; i < 11; i++) f[i] = PMAX;
    send(CMD_MUL, f);
    send(CMD_NSQ, f);
    send(CMD_NORM, f);
    send(CMD_INV, f);
    send(CMD_VROT, f);
    for (int i = 0; i < 11; i++) f[i] = NMAX;
    send(CMD_MUL, f);
    send(CMD_NORM, f);
    send(CMD_ROT, f);
    send(CMD_VROT, f);
    for (int i = 0; i < 11; i++) f[i] = 0;
    send(CMD_INV, f);                    // zero norm
    f[0] = 32'd1;
    send(CMD_INV, f);                    // squared norm truncates to zero
    f[0] = ONE; f[1] = ONE;
    send(CMD_INV, f);
    send(CMD_NSQ, f);
    f[1] = ONE; f[2] = 0; f[3] = 0;
    foreach (f[i]) if (i > 3) f[i] = ONE;
    f[0] = PI;       send(CMD_ROT, f);
    f[0] = -PI;      send(CMD_ROT, f);
    f[0] = PI << 1;  send(CMD_ROT, f);
    f[0] = PMAX;     send(CMD_ROT, f);
    f[0] = ONE; f[1] = 0; f[4] = ONE; f[5] = 0;
    send(CMD_VROT, f);
    send(3'd6, f);
    send(3'd7, f);

    for (int n = 0; n < 1200; n++) begin
      if (n == 400) begin
        // hold off until the pipe is empty
        in_tvalid <= 0;
        while (pending != 0) @(negedge clk);
      end
      if (n == 1000) calm = 1;
      send_rand($urandom_range(0, 19) == 0 ? 3'($urandom_range(6, 7))
                                           : 3'($urandom_range(0, 5)));
    end
    in_tvalid <= 0;

    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 100000) begin
      @(negedge clk);
      wait_cnt++;
    end
    repeat (60) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
